// File: rtl/core/rpn_stack_calculator_assert.svh
// assertion macros for the rpn stack calculator
// depends on nothing; included by modules that assert
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// implication checked every clock, quiet during reset
`define RPN_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// implication checked on the clock after the antecedent
`define RPN_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// File: rtl/core/rpn_pkg.sv
// types and constants for the rpn stack calculator
// depends on nothing
`default_nettype none
package rpn_pkg;
   localparam int unsigned QW = 32;

   typedef enum logic [3:0] {
      CMD_PUSH = 4'd0, CMD_ADD = 4'd1, CMD_SUB = 4'd2, CMD_MUL = 4'd3,
      CMD_DIV = 4'd4, CMD_MOD = 4'd5, CMD_POP = 4'd6, CMD_PEEK = 4'd7,
      CMD_DUP = 4'd8, CMD_SWAP = 4'd9, CMD_CLEAR = 4'd10
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_FULL = 3'd2, ST_ZERO_DIV = 3'd3,
      ST_SHORT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_B, S_WAIT_B, S_RD_A, S_WAIT_A, S_EXEC, S_MUL2,
      S_DIV, S_WRITE, S_SWAP2, S_DONE
   } state_type;

   // divider control
   typedef struct packed {
      logic start;
      logic is_mod;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
   localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

   function automatic logic [QW-1:0] clamp_q(input logic signed [63:0] v);
      logic [QW-1:0] r;
      if (v > Q_MAX) r = 32'h7fff_ffff;
      else if (v < Q_MIN) r = 32'h8000_0000;
      else r = v[QW-1:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/rpn_if.sv
// valid/ready channel interfaces for the calculator
// depends on nothing
`default_nettype none
interface rpn_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] req_type;
   logic signed [31:0] operand;
   modport source (output valid, req_type, operand, input ready);
   modport sink (input valid, req_type, operand, output ready);
endinterface

interface rpn_rsp_if;
   logic       valid;
   logic       ready;
   logic signed [31:0] shown_value;
   logic       shown_valid;
   logic [2:0] status;
   modport source (output valid, shown_value, shown_valid, status, input ready);
   modport sink (input valid, shown_value, shown_valid, status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rpn_ram.sv
// generic single port ram with registered read
// depends on nothing
`default_nettype none
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/rpn_div.sv
// iterative signed divider, one quotient bit per cycle
// depends on rpn_pkg; gives saturated q16.16 quotient or integer remainder
`default_nettype none
`include "rpn_stack_calculator_assert.svh"
module rpn_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rpn_pkg::div_ctl_type ctl,
   input  wire logic signed [63:0]  dividend,
   input  wire logic signed [31:0]  divisor,
   output rpn_pkg::div_stat_type    stat,
   output logic [31:0]              result
);
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in, negq_ff, negq_in;
   logic        negr_ff, negr_in, mod_ff, mod_in;
   logic [64:0] trial;
   logic [63:0] shifted;
   logic signed [64:0] sq;
   logic [63:0] mag_n;

   assign mag_n   = dividend[63] ? (~dividend + 64'd1) : dividend;
   assign shifted = {rem_ff[62:0], quo_ff[63]};
   assign trial   = {1'b0, shifted} - {1'b0, den_ff};

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0; negq_in = negq_ff; negr_in = negr_ff;
      mod_in = mod_ff;
      if (ctl.start) begin
         rem_in  = '0;
         quo_in  = mag_n;
         den_in  = {32'd0, divisor[31] ? (~divisor + 32'd1) : divisor};
         negq_in = dividend[63] ^ divisor[31];
         negr_in = dividend[63];
         mod_in  = ctl.is_mod;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; cnt_ff <= cnt_in;
      negq_ff <= negq_in; negr_ff <= negr_in; mod_ff <= mod_in;
   end

   always_comb begin
      sq = negq_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (mod_ff)
         result = negr_ff ? (~rem_ff[31:0] + 32'd1) : rem_ff[31:0];
      else if (!negq_ff && quo_ff[63:31] != 33'd0)
         result = 32'h7fff_ffff;
      else if (negq_ff && quo_ff > 64'h8000_0000)
         result = 32'h8000_0000;
      else
         result = sq[31:0];
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `RPN_ASSERT_NEXT(a_div_start_busy, clock, reset, ctl.start, busy_ff)
   `RPN_ASSERT_IMP(a_div_done_idle, clock, reset, done_ff, !busy_ff)
   `RPN_ASSERT_IMP(a_div_cnt_live, clock, reset, busy_ff, cnt_ff != 7'd0)
endmodule
`default_nettype wire

// File: rtl/core/rpn_stack_calculator.sv
// rpn calculator: one command per transaction, one response per command
// sequence: idle, exec, rd_b, wait_b, rd_a, wait_a, then mul2 for mul, div for div/mod
// (64 divider steps), write when the command writes (swap adds swap2), and done
// a new command is taken only once the last one has finished; ready only in idle
// a response held in the output register stalls only the end of the next command
// reset: synchronous active high, clears stack count, sequencer and response valid; ram not cleared
`default_nettype none
`include "rpn_stack_calculator_assert.svh"
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = 128
) (
   input wire logic clock,
   input wire logic reset,
   rpn_req_if.sink   req,
   rpn_rsp_if.source rsp
);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

   rpn_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [3:0]  cmd_ff, cmd_in;
   logic [31:0] opnd_ff, opnd_in, a_ff, a_in, b_ff, b_in, wd_ff, wd_in;
   logic [2:0]  st_ff, st_in;
   logic [31:0] sv_ff, sv_in;
   logic        svv_ff, svv_in, rv_ff, rv_in;
   logic [31:0] osv_ff, osv_in;
   logic        osvv_ff, osvv_in;
   logic [2:0]  ost_ff, ost_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [CW-1:0] wa_ff, wa_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [31:0]   ram_wd, ram_rd;
   rpn_pkg::div_ctl_type  dctl;
   rpn_pkg::div_stat_type dstat;
   logic signed [63:0] dvd;
   logic signed [31:0] dvs;
   logic [31:0] dres;
   logic signed [31:0] ia, ib;
   logic [CW-1:0] rd_addr;

   rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd),
      .rd_data(ram_rd));

   rpn_div u_div (.clock(clock), .reset(reset), .ctl(dctl), .dividend(dvd),
      .divisor(dvs), .stat(dstat), .result(dres));

   assign ia = $signed(a_ff) >>> 16;
   assign ib = $signed(b_ff) >>> 16;
   // truncate toward zero for mod
   logic signed [31:0] ta, tb;
   assign ta = ($signed(a_ff) < 0 && a_ff[15:0] != 16'd0) ? ia + 32'sd1 : ia;
   assign tb = ($signed(b_ff) < 0 && b_ff[15:0] != 16'd0) ? ib + 32'sd1 : ib;
   // mod divides by the integer part only
   assign dvs = (cmd_ff == rpn_pkg::CMD_MOD) ? tb : $signed(b_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpn_pkg::S_IDLE: if (req.valid) state_in = rpn_pkg::S_EXEC;
         rpn_pkg::S_RD_B: state_in = rpn_pkg::S_WAIT_B;
         rpn_pkg::S_WAIT_B: state_in = rpn_pkg::S_RD_A;
         rpn_pkg::S_RD_A: state_in = rpn_pkg::S_WAIT_A;
         rpn_pkg::S_WAIT_A: state_in = rpn_pkg::S_MUL2;
         rpn_pkg::S_EXEC: state_in = rpn_pkg::S_RD_B;
         rpn_pkg::S_MUL2: state_in = rpn_pkg::S_WRITE;
         rpn_pkg::S_DIV: if (dstat.done) state_in = rpn_pkg::S_WRITE;
         rpn_pkg::S_WRITE: state_in = rpn_pkg::S_DONE;
         rpn_pkg::S_SWAP2: state_in = rpn_pkg::S_DONE;
         rpn_pkg::S_DONE: if (!rv_ff || rsp.ready) state_in = rpn_pkg::S_IDLE;
         default: state_in = rpn_pkg::S_IDLE;
      endcase
   end

   // datapath and sequencing
   always_comb begin
      cnt_in = cnt_ff; cmd_in = cmd_ff; opnd_in = opnd_ff; a_in = a_ff;
      b_in = b_ff; wd_in = wd_ff; st_in = st_ff; sv_in = sv_ff;
      svv_in = svv_ff; rv_in = rv_ff; prod_in = prod_ff; wa_in = wa_ff;
      osv_in = osv_ff; osvv_in = osvv_ff; ost_in = ost_ff;
      ram_we = 1'b0; ram_wd = wd_ff; rd_addr = cnt_ff - CW'(1);
      dctl = '0;
      dvd = (cmd_ff == rpn_pkg::CMD_MOD) ? 64'(ta) : {{16{a_ff[31]}}, a_ff, 16'd0};
      if (rsp.ready && rv_ff) rv_in = 1'b0;
      case (state_ff)
         rpn_pkg::S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.req_type; opnd_in = req.operand;
               st_in = rpn_pkg::ST_OK; sv_in = '0; svv_in = 1'b0;
            end
         end
         rpn_pkg::S_EXEC: begin
            // read top (address cnt-1) is presented in this state
            rd_addr = cnt_ff - CW'(1);
         end
         rpn_pkg::S_RD_B: begin
            // ram_rd holds top, the entry below is presented
            rd_addr = cnt_ff - CW'(2);
            b_in = (cnt_ff == '0) ? '0 : ram_rd;
         end
         rpn_pkg::S_WAIT_B: begin
            // ram_rd holds the entry below top
            a_in = (cnt_ff < CW'(2)) ? '0 : ram_rd;
         end
         default: ;
      endcase
      // command decisions at WAIT_A, with a and b loaded
      if (state_ff == rpn_pkg::S_WAIT_A) begin
         wa_in = cnt_ff;
         prod_in = $signed(a_ff) * $signed(b_ff);
         case (cmd_ff)
            rpn_pkg::CMD_PUSH: begin
               if (cnt_ff == FULL) st_in = rpn_pkg::ST_FULL;
               else begin wd_in = opnd_ff; wa_in = cnt_ff; cnt_in = cnt_ff + CW'(1); end
            end
            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL: begin
               if (cnt_ff < CW'(2)) st_in = rpn_pkg::ST_EMPTY;
               wa_in = (cnt_ff < CW'(2)) ? '0 : cnt_ff - CW'(2);
               cnt_in = wa_in + CW'(1);
               wd_in = (cmd_ff == rpn_pkg::CMD_ADD) ?
                  rpn_pkg::clamp_q(64'($signed(a_ff)) + 64'($signed(b_ff))) :
                  rpn_pkg::clamp_q(64'($signed(a_ff)) - 64'($signed(b_ff)));
            end
            rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: begin
               if (cnt_ff == '0) begin
                  st_in = rpn_pkg::ST_EMPTY;
               end else if ((cmd_ff == rpn_pkg::CMD_DIV && b_ff == '0) ||
                            (cmd_ff == rpn_pkg::CMD_MOD && tb == '0)) begin
                  st_in = rpn_pkg::ST_ZERO_DIV; cnt_in = cnt_ff - CW'(1);
               end else begin
                  if (cnt_ff < CW'(2)) st_in = rpn_pkg::ST_EMPTY;
                  wa_in = (cnt_ff < CW'(2)) ? '0 : cnt_ff - CW'(2);
                  cnt_in = wa_in + CW'(1);
                  dctl.start = 1'b1;
                  dctl.is_mod = (cmd_ff == rpn_pkg::CMD_MOD);
               end
            end
            rpn_pkg::CMD_POP: begin
               svv_in = 1'b1;
               if (cnt_ff == '0) st_in = rpn_pkg::ST_EMPTY;
               else begin sv_in = b_ff; cnt_in = cnt_ff - CW'(1); end
            end
            rpn_pkg::CMD_PEEK: begin
               if (cnt_ff == '0) st_in = rpn_pkg::ST_EMPTY;
               else begin sv_in = b_ff; svv_in = 1'b1; end
            end
            rpn_pkg::CMD_DUP: begin
               if (cnt_ff == '0) st_in = rpn_pkg::ST_EMPTY;
               else if (cnt_ff == FULL) st_in = rpn_pkg::ST_FULL;
               else begin wd_in = b_ff; cnt_in = cnt_ff + CW'(1); end
            end
            rpn_pkg::CMD_SWAP: begin
               if (cnt_ff < CW'(2)) st_in = rpn_pkg::ST_SHORT;
               else begin wd_in = b_ff; wa_in = cnt_ff - CW'(2); end
            end
            rpn_pkg::CMD_CLEAR: cnt_in = '0;
            default: ;
         endcase
      end
      if (state_ff == rpn_pkg::S_MUL2 && cmd_ff == rpn_pkg::CMD_MUL)
         wd_in = rpn_pkg::clamp_q(prod_ff / 64'sd65536);
      if (state_ff == rpn_pkg::S_DIV && dstat.done)
         wd_in = (cmd_ff == rpn_pkg::CMD_MOD) ? {dres[15:0], 16'd0} : dres;
      if (state_ff == rpn_pkg::S_WRITE) begin
         ram_we = 1'b1; rd_addr = wa_ff;
         // swap also writes a to the top slot
         if (cmd_ff == rpn_pkg::CMD_SWAP) wd_in = a_ff;
      end
      if (state_ff == rpn_pkg::S_SWAP2) begin
         ram_we = 1'b1; rd_addr = wa_ff + CW'(1); ram_wd = wd_ff;
      end
      // hand the finished response to the output register once it is free
      if (state_ff == rpn_pkg::S_DONE && (!rv_ff || rsp.ready)) begin
         rv_in = 1'b1; osv_in = sv_ff; osvv_in = svv_ff; ost_in = st_ff;
      end
      ram_addr = rd_addr[AW-1:0];
   end

   // post-decision routing, overriding the plain sequence
   rpn_pkg::state_type st_next;
   logic               do_write;
   always_comb begin
      st_next = state_in;
      do_write = 1'b0;
      if (state_ff == rpn_pkg::S_WAIT_A) begin
         case (cmd_ff)
            rpn_pkg::CMD_PUSH: do_write = (cnt_ff != FULL);
            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB: do_write = 1'b1;
            rpn_pkg::CMD_DUP: do_write = (cnt_ff != '0) && (cnt_ff != FULL);
            rpn_pkg::CMD_SWAP: do_write = (cnt_ff >= CW'(2));
            default: do_write = 1'b0;
         endcase
         if (cmd_ff == rpn_pkg::CMD_MUL) st_next = rpn_pkg::S_MUL2;
         else if (dctl.start) st_next = rpn_pkg::S_DIV;
         else if (do_write) st_next = rpn_pkg::S_WRITE;
         else st_next = rpn_pkg::S_DONE;
      end
      if (state_ff == rpn_pkg::S_WRITE && cmd_ff == rpn_pkg::CMD_SWAP)
         st_next = rpn_pkg::S_SWAP2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpn_pkg::S_IDLE; cnt_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= st_next; cnt_ff <= cnt_in; rv_ff <= rv_in;
      end
      cmd_ff <= cmd_in; opnd_ff <= opnd_in; a_ff <= a_in; b_ff <= b_in;
      wd_ff <= wd_in; st_ff <= st_in; sv_ff <= sv_in;
      svv_ff <= svv_in; prod_ff <= prod_in; wa_ff <= wa_in;
      osv_ff <= osv_in; osvv_ff <= osvv_in; ost_ff <= ost_in;
   end

   assign req.ready       = (state_ff == rpn_pkg::S_IDLE);
   assign rsp.valid       = rv_ff;
   assign rsp.shown_value = osv_ff;
   assign rsp.shown_valid = osvv_ff;
   assign rsp.status      = ost_ff;

   `RPN_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= FULL)
   `RPN_ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && !rsp.ready, rv_ff && $stable(osv_ff) && $stable(ost_ff))
   `RPN_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req.valid && req.ready, state_ff == rpn_pkg::S_EXEC)
endmodule
`default_nettype wire
